[hw/rtl/pixel_format_to_rgb8_preview_top_defines.svh]
// Assertion macros shared by the texel preview converter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PIXEL_FORMAT_TO_RGB8_PREVIEW_TOP_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGB8_PREVIEW_TOP_DEFINES_SVH

// Condition in this cycle implies consequence in the next cycle
`define PFTR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

// Condition implies consequence in the same cycle
`define PFTR_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checked through reset: reset low forces the consequence next cycle
`define PFTR_ASSERT_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pftr_pkg.sv]
// Package for the texel preview converter: format codes and channel math.
// No dependencies; used by pftr_lane, pftr_merge and the top level.
package pftr_pkg;

    typedef enum logic [2:0] {
        FMT_R8      = 3'd0,
        FMT_R16F    = 3'd1,
        FMT_RGB10A2 = 3'd2,
        FMT_R32F    = 3'd3,
        FMT_RGBA8   = 3'd4,
        FMT_BGRA8   = 3'd5,
        FMT_RGBA16F = 3'd6,
        FMT_RGBA32F = 3'd7
    } t_fmt;

    localparam int NUM_LANES = 3;
    localparam logic [1:0] LANE_RED   = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_BLUE  = 2'd2;

    // Reciprocal of 1023 scaled by 2^28, rounded up
    localparam logic [18:0] RECIP_1023 = 19'd262401;
    localparam int          RECIP_SHIFT = 28;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Half float to binary32 bits, subnormals normalized exactly
    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic       s;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] lz;
        logic [3:0] t;
        logic [7:0] ex;
        logic [9:0] mm;
        logic       found;
        s = h[15];
        e = h[14:10];
        m = h[9:0];
        lz = 4'd0;
        found = 1'b0;
        for (int i = 9; i >= 0; i--) begin
            if (!found && m[i]) begin
                found = 1'b1;
                lz = 4'(9 - i);
            end
        end
        t  = 4'd9 - lz;
        ex = 8'd103 + {4'd0, t};
        mm = 10'(m << (lz + 4'd1));
        if (e == 5'd31) begin
            half_to_f32 = {s, 8'hFF, m, 13'd0};
        end else if (e == 5'd0) begin
            if (m == 10'd0) begin
                half_to_f32 = {s, 31'd0};
            end else begin
                half_to_f32 = {s, ex, mm, 13'd0};
            end
        end else begin
            half_to_f32 = {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
        end
    endfunction

    // x / 255 rounded to binary32; the quotient is the byte repeated
    function automatic logic [31:0] u8_to_f32(input logic [7:0] x);
        logic [2:0]  lz;
        logic        found;
        logic [39:0] ws;
        logic [24:0] r;
        found = 1'b0;
        lz = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!found && x[i]) begin
                found = 1'b1;
                lz = 3'(7 - i);
            end
        end
        ws = {x, x, x, x, x} << lz;
        // tail below the guard bit is never zero, so no ties
        r  = {1'b0, ws[39:16]} + {24'd0, ws[15]};
        if (x == 8'd0) begin
            u8_to_f32 = 32'd0;
        end else if (r[24]) begin
            u8_to_f32 = {1'b0, 8'(8'd127 - {5'd0, lz}), 23'd0};
        end else begin
            u8_to_f32 = {1'b0, 8'(8'd126 - {5'd0, lz}), r[22:0]};
        end
    endfunction

    // floor(x * 255 / 1023), matches the float divide-multiply-truncate
    function automatic logic [7:0] u10_to_u8(input logic [9:0] x);
        logic [17:0] n;
        logic [36:0] p;
        n = {x, 8'd0} - {8'd0, x};
        p = {19'd0, n} * {18'd0, RECIP_1023};
        u10_to_u8 = p[RECIP_SHIFT +: 8];
    endfunction

    // Clamp to 0..1, multiply by 255 in binary32, truncate; Inf and NaN give 255, or 0 on the green lane
    function automatic logic [7:0] f32_to_u8(input logic [31:0] b, input logic is_green);
        logic        s;
        logic [7:0]  e;
        logic [23:0] m;
        logic [31:0] p;
        logic [23:0] sig;
        logic        g;
        logic        st;
        logic        l;
        logic [3:0]  sh;
        logic [24:0] r;
        logic [4:0]  amt;
        logic [24:0] q;
        s = b[31];
        e = b[30:23];
        m = {1'b1, b[22:0]};
        p = {m, 8'd0} - {8'd0, m};
        if (p[31]) begin
            sig = p[31:8]; g = p[7]; st = |p[6:0]; l = p[8]; sh = 4'd8;
        end else begin
            sig = p[30:7]; g = p[6]; st = |p[5:0]; l = p[7]; sh = 4'd7;
        end
        r   = {1'b0, sig} + {24'd0, g & (st | l)};
        amt = 5'(8'd150 - e - {4'd0, sh});
        q   = r >> amt;
        if (e == 8'hFF) begin
            f32_to_u8 = is_green ? 8'd0 : 8'd255;
        end else if (s || e < 8'd119) begin
            f32_to_u8 = 8'd0;
        end else if (e >= 8'd127) begin
            f32_to_u8 = 8'd255;
        end else begin
            f32_to_u8 = q[7:0];
        end
    endfunction

endpackage

[hw/rtl/pftr_lane.sv]
// One channel lane: picks its bits from the texel, decodes and scales to 8 bits.
// Depends on pftr_pkg.
module pftr_lane (
    input  logic [63:0] i_lo,
    input  logic [31:0] i_hi,
    input  logic [2:0]  i_fmt,
    input  logic [1:0]  i_lane,
    output logic [7:0]  o_chan
);

    logic [7:0]  byte_sel;
    logic [15:0] half_sel;
    logic [31:0] word_sel;
    logic [31:0] fbits;
    logic [9:0]  u10;

    // Source slice for this lane
    always_comb begin
        half_sel = i_lo[{i_lane, 4'd0} +: 16];
        word_sel = (i_lane == pftr_pkg::LANE_BLUE) ? i_hi : i_lo[{i_lane[0], 5'd0} +: 32];
        u10      = i_lo[6'({4'd0, i_lane} * 6'd10) +: 10];
        byte_sel = i_lo[7:0];
        case (pftr_pkg::t_fmt'(i_fmt))
            pftr_pkg::FMT_RGBA8: byte_sel = i_lo[{i_lane, 3'd0} +: 8];
            pftr_pkg::FMT_BGRA8: byte_sel = i_lo[{2'(2'd2 - i_lane), 3'd0} +: 8];
            default:             byte_sel = i_lo[7:0];
        endcase
    end

    // Decode to binary32
    always_comb begin
        unique case (pftr_pkg::t_fmt'(i_fmt))
            pftr_pkg::FMT_R16F:    fbits = pftr_pkg::half_to_f32(i_lo[15:0]);
            pftr_pkg::FMT_RGBA16F: fbits = pftr_pkg::half_to_f32(half_sel);
            pftr_pkg::FMT_R32F:    fbits = i_lo[31:0];
            pftr_pkg::FMT_RGBA32F: fbits = word_sel;
            default:               fbits = pftr_pkg::u8_to_f32(byte_sel);
        endcase
    end

    // 10-bit unorm takes an integer path
    assign o_chan = (pftr_pkg::t_fmt'(i_fmt) == pftr_pkg::FMT_RGB10A2)
                  ? pftr_pkg::u10_to_u8(u10)
                  : pftr_pkg::f32_to_u8(fbits, i_lane == pftr_pkg::LANE_GREEN);

endmodule

[hw/rtl/pftr_merge.sv]
// Merge stage: gathers the lane results into one registered output beat.
// Depends on pftr_pkg and the assertion macro header.
`include "pixel_format_to_rgb8_preview_top_defines.svh"
module pftr_merge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pftr_pkg::t_rgb   i_rgb,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_busy,
    output pftr_pkg::t_rgb   o_rgb
);

    logic           r_valid;
    logic           n_valid;
    pftr_pkg::t_rgb r_rgb;

    // Output beat is held while stalled
    assign o_busy  = r_valid && i_stall;
    assign n_valid = i_load || o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rgb <= i_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

    `PFTR_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_load, r_valid && r_rgb == $past(i_rgb), "loaded beat not presented")
    `PFTR_ASSERT_NOW(a_no_load_busy, i_clk, i_rst_n, o_busy, !i_load, "load while output held")
    `PFTR_ASSERT_RESET(a_reset_clear, i_clk, i_rst_n, !r_valid, "valid set after reset")

endmodule

[hw/rtl/pixel_format_to_rgb8_preview_top.sv]
// Top level of the texel preview converter: format register, three lanes, merge.
// Depends on pftr_pkg, pftr_lane, pftr_merge.
//
//  channel | signals                          | width
//  in      | i_valid o_stall i_texel_*        | 64 + 32
//  out     | o_valid i_stall o_red/green/blue | 8 x 3
//  cfg     | i_cfg_we i_cfg_wdata             | 3
//
// One texel per cycle unless stalled; each result appears in the cycle after its
// beat is taken, held in the single merge register after the lanes.
// Reset is synchronous and empties the output register; format resets to r8.
// A stall holds the output beat and stalls the input only while a beat waits.
module pixel_format_to_rgb8_preview_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_texel_low,
    input  logic [31:0] i_texel_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    logic [2:0]     r_pixel_format;
    logic [7:0]     lane_out [pftr_pkg::NUM_LANES];
    pftr_pkg::t_rgb rgb;
    pftr_pkg::t_rgb out_rgb;
    logic           busy;
    logic           load;

    // Format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= pftr_pkg::FMT_R8;
        end else if (i_cfg_we) begin
            r_pixel_format <= i_cfg_wdata;
        end
    end

    // Channel lanes
    for (genvar g = 0; g < pftr_pkg::NUM_LANES; g++) begin : g_lane
        pftr_lane u_lane (
            .i_lo   (i_texel_low),
            .i_hi   (i_texel_high),
            .i_fmt  (r_pixel_format),
            .i_lane (2'(g)),
            .o_chan (lane_out[g])
        );
    end

    assign rgb  = '{red: lane_out[0], green: lane_out[1], blue: lane_out[2]};
    assign load = i_valid && !busy;

    pftr_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_rgb   (rgb),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_busy  (busy),
        .o_rgb   (out_rgb)
    );

    assign o_stall = busy;
    assign o_red   = out_rgb.red;
    assign o_green = out_rgb.green;
    assign o_blue  = out_rgb.blue;

endmodule
